@@ design/button_click_event_detector_macros.svh @@
// Assertion macros for the button click event detector.
`ifndef BUTTON_CLICK_EVENT_DETECTOR_MACROS_SVH
`define BUTTON_CLICK_EVENT_DETECTOR_MACROS_SVH

`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset.
`define BCED_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("button detector check failed");
// Check that an antecedent implies a consequence in the cycle after it, outside reset.
`define BCED_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("button detector sequence check failed");
`else
`define BCED_ASSERT(lbl, cond)
`define BCED_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ design/bced_pkg.sv @@
// Shared constants of the button click event detector.
`default_nettype none

package bced_pkg;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;
    localparam int EVENT_BITS     = 3;

    // Register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_ACTIVE_LEVEL = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DEBOUNCE     = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LONG_PRESS   = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CLICK_WINDOW = 2'd3;

    // Register reset values
    localparam logic [CFG_DATA_BITS-1:0] DEBOUNCE_RESET     = 16'd3;
    localparam logic [CFG_DATA_BITS-1:0] LONG_PRESS_RESET   = 16'd100;
    localparam logic [CFG_DATA_BITS-1:0] CLICK_WINDOW_RESET = 16'd35;

    // Event codes
    typedef logic [EVENT_BITS-1:0] event_t;
    localparam event_t EV_NONE   = 3'd0;
    localparam event_t EV_PRESS  = 3'd1;
    localparam event_t EV_LONG   = 3'd2;
    localparam event_t EV_CLICK  = 3'd3;
    localparam event_t EV_DOUBLE = 3'd4;

    localparam logic [1:0] CLICKS_NONE = 2'd0;
    localparam logic [1:0] CLICKS_ONE  = 2'd1;
    localparam logic [1:0] CLICKS_TWO  = 2'd2;

endpackage

`default_nettype wire

@@ design/button_click_event_detector.sv @@
// Button debounce with press, long press, click and double click events.
//
// Usage: each input item is one poll tick carrying raw_level, the sampled
// pin level. Items arrive on in_valid/in_stall; one result item per tick
// leaves on out_valid/out_stall with event_code (0 none, 1 press, 2 long
// press, 3 click, 4 double click) and held, the debounced state.
// Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high. Write only while no tick is in flight.
// A tick accepted into the input register leaves through the result register;
// the state update between the two registers is combinational, so one tick
// per cycle passes while the receiver does not stall.
// When the receiver stalls, the result register holds and the input
// register still takes one more tick; in_stall rises only when both are
// full. Reset (rst_n low, asynchronous) empties both registers, loads the
// register defaults and starts with the button released, all ages zero
// and no clicks pending.
`default_nettype none

`include "button_click_event_detector_macros.svh"

module button_click_event_detector #(
    parameter int AGE_BITS = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic                                raw_level,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output bced_pkg::event_t                         event_code,
    output logic                                     held,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [bced_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [bced_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int CMP_BITS = (AGE_BITS > bced_pkg::CFG_DATA_BITS)
                              ? AGE_BITS : bced_pkg::CFG_DATA_BITS;
    localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

    // Configuration registers
    logic                               active_level_reg;
    logic [bced_pkg::CFG_DATA_BITS-1:0] debounce_reg;
    logic [bced_pkg::CFG_DATA_BITS-1:0] long_press_reg;
    logic [bced_pkg::CFG_DATA_BITS-1:0] click_window_reg;

    // Input register
    logic item_valid_reg;
    logic item_level_reg;

    // Tracking state
    logic                raw_pressed_reg, raw_pressed_next;
    logic                stable_reg, stable_next;
    logic [AGE_BITS-1:0] raw_age_reg, raw_age_next;
    logic [AGE_BITS-1:0] press_age_reg, press_age_next;
    logic [AGE_BITS-1:0] release_age_reg, release_age_next;
    logic                long_reported_reg, long_reported_next;
    logic [1:0]          clicks_reg, clicks_next;

    // Result register
    logic              out_valid_reg;
    bced_pkg::event_t  event_reg, event_next;
    logic              held_reg;

    logic move;
    logic now_pressed;
    logic pressed_now;

    assign cfg_ready  = 1'b1;
    assign move       = item_valid_reg && !(out_valid_reg && out_stall);
    assign in_stall   = item_valid_reg && !move;
    assign out_valid  = out_valid_reg;
    assign event_code = event_reg;
    assign held       = held_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_level_reg <= 1'b0;
            debounce_reg     <= bced_pkg::DEBOUNCE_RESET;
            long_press_reg   <= bced_pkg::LONG_PRESS_RESET;
            click_window_reg <= bced_pkg::CLICK_WINDOW_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bced_pkg::REG_ACTIVE_LEVEL: active_level_reg <= cfg_data[0];
                bced_pkg::REG_DEBOUNCE:     debounce_reg     <= cfg_data;
                bced_pkg::REG_LONG_PRESS:   long_press_reg   <= cfg_data;
                bced_pkg::REG_CLICK_WINDOW: click_window_reg <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // Compute the next state and event for the item in the input register
    always_comb
    begin
        now_pressed        = (item_level_reg == active_level_reg);
        raw_pressed_next   = raw_pressed_reg;
        stable_next        = stable_reg;
        long_reported_next = long_reported_reg;
        clicks_next        = clicks_reg;
        event_next         = bced_pkg::EV_NONE;
        pressed_now        = 1'b0;

        // advance ages with saturation
        raw_age_next     = (raw_age_reg == AGE_MAX) ? AGE_MAX : raw_age_reg + 1'b1;
        press_age_next   = (press_age_reg == AGE_MAX) ? AGE_MAX : press_age_reg + 1'b1;
        release_age_next = (release_age_reg == AGE_MAX)
                           ? AGE_MAX : release_age_reg + 1'b1;

        // restart the raw age on a level change
        if (now_pressed != raw_pressed_reg)
        begin
            raw_pressed_next = now_pressed;
            raw_age_next     = '0;
        end

        // follow the raw level once it has been steady
        if ((CMP_BITS'(raw_age_next) >= CMP_BITS'(debounce_reg))
            && (stable_reg != raw_pressed_next))
        begin
            stable_next = raw_pressed_next;
            if (raw_pressed_next)
            begin
                press_age_next     = '0;
                long_reported_next = 1'b0;
                event_next         = bced_pkg::EV_PRESS;
                pressed_now        = 1'b1;
            end
            else if (!long_reported_reg)
            begin
                if (clicks_reg != bced_pkg::CLICKS_TWO)
                begin
                    clicks_next = clicks_reg + 1'b1;
                end
                release_age_next = '0;
            end
        end

        // fire long press once per hold and drop pending clicks
        if (!pressed_now && stable_next && !long_reported_next
            && (CMP_BITS'(press_age_next) >= CMP_BITS'(long_press_reg)))
        begin
            long_reported_next = 1'b1;
            clicks_next        = bced_pkg::CLICKS_NONE;
            event_next         = bced_pkg::EV_LONG;
        end

        // report counted clicks when the window expires
        if (!stable_next && (clicks_next != bced_pkg::CLICKS_NONE)
            && (CMP_BITS'(release_age_next) >= CMP_BITS'(click_window_reg)))
        begin
            event_next  = (clicks_next == bced_pkg::CLICKS_ONE)
                          ? bced_pkg::EV_CLICK : bced_pkg::EV_DOUBLE;
            clicks_next = bced_pkg::CLICKS_NONE;
        end
    end

    // Hold control state; update it as the item moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg    <= 1'b0;
            out_valid_reg     <= 1'b0;
            raw_pressed_reg   <= 1'b0;
            stable_reg        <= 1'b0;
            raw_age_reg       <= '0;
            press_age_reg     <= '0;
            release_age_reg   <= '0;
            long_reported_reg <= 1'b0;
            clicks_reg        <= bced_pkg::CLICKS_NONE;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (move)
            begin
                item_valid_reg <= 1'b0;
            end

            if (move)
            begin
                out_valid_reg     <= 1'b1;
                raw_pressed_reg   <= raw_pressed_next;
                stable_reg        <= stable_next;
                raw_age_reg       <= raw_age_next;
                press_age_reg     <= press_age_next;
                release_age_reg   <= release_age_next;
                long_reported_reg <= long_reported_next;
                clicks_reg        <= clicks_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture payloads
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_level_reg <= raw_level;
        end
        if (move)
        begin
            event_reg <= event_next;
            held_reg  <= stable_next;
        end
    end

    `BCED_ASSERT(a_click_saturates, clicks_reg != 2'd3)
    `BCED_ASSERT(a_long_while_held,
        !(out_valid_reg && (event_reg == bced_pkg::EV_LONG)) || held_reg)
    `BCED_ASSERT(a_press_while_held,
        !(out_valid_reg && (event_reg == bced_pkg::EV_PRESS)) || held_reg)
    `BCED_ASSERT(a_click_while_released,
        !(out_valid_reg && ((event_reg == bced_pkg::EV_CLICK)
                            || (event_reg == bced_pkg::EV_DOUBLE))) || !held_reg)
    `BCED_ASSERT(a_stall_only_when_full, !in_stall || (item_valid_reg && out_valid_reg))
    `BCED_ASSERT_NEXT(a_move_fills_output, move, out_valid_reg)

endmodule

`default_nettype wire

@@ test/button_click_event_detector_tb.sv @@
// Testbench for the button click event detector: directed and random ticks vs. a predictor.
module button_click_event_detector_tb;

    localparam int AGE_BITS        = 16;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int PHASE_TICKS     = 270;
    localparam int PHASE_COUNT     = 5;
    localparam int MAX_REPORTS     = 10;
    localparam int LONG_RUN_TICKS  = 100;

    typedef struct packed {
        bced_pkg::event_t ev;
        logic             held;
    } tick_result_t;

    logic                                clk;
    logic                                rst_n;
    logic                                in_valid;
    logic                                in_stall;
    logic                                raw_level;
    logic                                out_valid;
    logic                                out_stall;
    bced_pkg::event_t                    event_code;
    logic                                held;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [bced_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [bced_pkg::CFG_DATA_BITS-1:0]  cfg_data;

    // Predicted button state and settings
    logic                               act_level;
    logic [bced_pkg::CFG_DATA_BITS-1:0] debounce_len;
    logic [bced_pkg::CFG_DATA_BITS-1:0] long_len;
    logic [bced_pkg::CFG_DATA_BITS-1:0] window_len;
    logic                               raw_on;
    logic                               stable_on;
    logic [AGE_BITS-1:0]                raw_age;
    logic [AGE_BITS-1:0]                press_age;
    logic [AGE_BITS-1:0]                release_age;
    logic                               long_done;
    logic [1:0]                         clicks;

    tick_result_t expected_results[$];
    int           ticks_sent    = 0;
    int           results_seen  = 0;
    int           fail_count    = 0;
    int           send_idle_pct = 27;
    int           take_idle_pct = 27;
    bit           hold_off_req  = 1'b0;

    button_click_event_detector #(
        .AGE_BITS(AGE_BITS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .raw_level (raw_level),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .event_code(event_code),
        .held      (held),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("MISMATCH: %s", msg);
    endfunction

    function automatic logic [AGE_BITS-1:0] age_step(input logic [AGE_BITS-1:0] age);
        return (age == '1) ? age : age + 1'b1;
    endfunction

    // Advance the predicted button state by one tick and return its event
    function automatic tick_result_t advance_button(input logic level);
        tick_result_t res;
        logic         now_on;
        logic         fresh_press;
        now_on      = (level == act_level);
        res.ev      = bced_pkg::EV_NONE;
        fresh_press = 1'b0;

        raw_age     = age_step(raw_age);
        press_age   = age_step(press_age);
        release_age = age_step(release_age);

        if (now_on != raw_on)
        begin
            raw_on  = now_on;
            raw_age = '0;
        end

        // Debounce: follow the raw bit once it has been steady long enough
        if (raw_age >= debounce_len && stable_on != raw_on)
        begin
            stable_on = raw_on;
            if (stable_on)
            begin
                press_age   = '0;
                long_done   = 1'b0;
                res.ev      = bced_pkg::EV_PRESS;
                fresh_press = 1'b1;
            end
            else if (!long_done)
            begin
                if (clicks != bced_pkg::CLICKS_TWO)
                    clicks = clicks + 1'b1;
                release_age = '0;
            end
        end

        // Long press fires once per hold and drops pending clicks
        if (!fresh_press && stable_on && !long_done && press_age >= long_len)
        begin
            long_done = 1'b1;
            clicks    = bced_pkg::CLICKS_NONE;
            res.ev    = bced_pkg::EV_LONG;
        end

        // Resolve counted clicks once the window after release expires
        if (!stable_on && clicks != bced_pkg::CLICKS_NONE && release_age >= window_len)
        begin
            res.ev = (clicks == bced_pkg::CLICKS_ONE) ? bced_pkg::EV_CLICK
                                                      : bced_pkg::EV_DOUBLE;
            clicks = bced_pkg::CLICKS_NONE;
        end

        res.held = stable_on;
        return res;
    endfunction

    // Write all four registers back to back; call only while idle
    task automatic configure(input logic [bced_pkg::CFG_DATA_BITS-1:0] level_word,
                             input logic [bced_pkg::CFG_DATA_BITS-1:0] deb,
                             input logic [bced_pkg::CFG_DATA_BITS-1:0] lp,
                             input logic [bced_pkg::CFG_DATA_BITS-1:0] win);
        logic [bced_pkg::CFG_INDEX_BITS-1:0] idx  [4];
        logic [bced_pkg::CFG_DATA_BITS-1:0]  word [4];
        idx  = '{bced_pkg::REG_ACTIVE_LEVEL, bced_pkg::REG_DEBOUNCE,
                 bced_pkg::REG_LONG_PRESS, bced_pkg::REG_CLICK_WINDOW};
        word = '{level_word, deb, lp, win};
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= word[i];
            do @(posedge clk); while (!cfg_ready);
            case (idx[i])
                bced_pkg::REG_ACTIVE_LEVEL: act_level    = word[i][0];
                bced_pkg::REG_DEBOUNCE:     debounce_len = word[i];
                bced_pkg::REG_LONG_PRESS:   long_len     = word[i];
                bced_pkg::REG_CLICK_WINDOW: window_len   = word[i];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // Offer one tick, idling at random first, and predict its result
    task automatic send_tick(input logic level);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        raw_level <= level;
        do @(posedge clk); while (in_stall);
        expected_results.push_back(advance_button(level));
        ticks_sent++;
    endtask

    // Send n ticks with the button pressed or released
    task automatic send_run(input logic pressed, input int n);
        for (int i = 0; i < n; i++)
            send_tick(pressed ? act_level : ~act_level);
    endtask

    task automatic send_noise(input int n);
        for (int i = 0; i < n; i++)
            send_tick(logic'($urandom_range(1)));
    endtask

    // Drop valid and wait until every predicted result has come back
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_results.size() != 0);
    endtask

    // Press and release with reset settings: active low, debounce of three
    task automatic test_reset_defaults();
        send_run(1'b0, 2);
        send_run(1'b1, 6);
        send_run(1'b0, 6);
        drain();
    endtask

    // Single, double and triple clicks, and a glitch shorter than the debounce
    task automatic test_clicks();
        configure(16'hFFFF, 16'd1, 16'd6, 16'd3);
        send_run(1'b1, 3);
        send_run(1'b0, 6);
        send_run(1'b1, 2);
        send_run(1'b0, 2);
        send_run(1'b1, 2);
        send_run(1'b0, 6);
        for (int i = 0; i < 3; i++)
        begin
            send_run(1'b1, 2);
            send_run(1'b0, 2);
        end
        send_run(1'b0, 4);
        send_run(1'b1, 1);
        send_run(1'b0, 3);
        drain();
    endtask

    // Long press with no click on release, and a long press canceling a pending click
    task automatic test_long_press();
        send_run(1'b1, 10);
        send_run(1'b0, 6);
        send_run(1'b1, 2);
        send_run(1'b0, 2);
        send_run(1'b1, 10);
        send_run(1'b0, 6);
        drain();
    endtask

    // Zero debounce, long press and window: events land on the same or next tick
    task automatic test_zero_settings();
        configure(16'hFFFE, 16'd0, 16'd0, 16'd0);
        send_run(1'b0, 2);
        send_run(1'b1, 1);
        send_run(1'b0, 1);
        send_run(1'b1, 2);
        send_run(1'b0, 2);
        drain();
    endtask

    // Long holds and releases under the largest long press and window settings, no idling
    task automatic test_age_limits();
        send_idle_pct = 0;
        take_idle_pct = 0;
        configure(16'h0001, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_run(1'b0, 4);
        send_run(1'b1, LONG_RUN_TICKS);
        drain();
        configure(16'h0001, 16'd1, 16'hFFFF, 16'hFFFF);
        send_run(1'b0, 3);
        send_run(1'b1, 3);
        send_run(1'b0, LONG_RUN_TICKS);
        drain();
        send_idle_pct = 27;
        take_idle_pct = 27;
    endtask

    // Hold off the receiver while the sender keeps offering ticks
    task automatic test_backpressure();
        configure(16'h0001, 16'd2, 16'd12, 16'd5);
        send_idle_pct = 0;
        hold_off_req  = 1'b1;
        for (int i = 0; i < 40; i++)
        begin
            if (i % 8 < 4)
                send_run(1'b1, 1);
            else
                send_run(1'b0, 1);
        end
        send_idle_pct = 27;
        drain();
    endtask

    // One press and release with random lengths, or plain pin noise
    task automatic random_gesture();
        int kind;
        int lp;
        int win;
        kind = $urandom_range(99);
        lp   = int'(long_len);
        win  = int'(window_len);
        if (kind < 80)
        begin
            if ($urandom_range(3) == 0)
                send_noise($urandom_range(1, 4));
            send_run(1'b1, $urandom_range(1, lp + lp / 2 + 2));
            if ($urandom_range(3) == 0)
                send_noise($urandom_range(1, 4));
            send_run(1'b0, $urandom_range(1, 2 * win + 4));
        end
        else
            send_noise($urandom_range(1, 8));
    endtask

    task automatic test_random_phases();
        int phase_start;
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            send_idle_pct = (phase == 2) ? 0 : 27;
            take_idle_pct = (phase == 2) ? 0 : 27;
            configure(16'($urandom_range(65535)), 16'($urandom_range(1, 4)),
                      16'($urandom_range(1, 40)), 16'($urandom_range(1, 20)));
            phase_start = ticks_sent;
            while (ticks_sent - phase_start < PHASE_TICKS)
                random_gesture();
            drain();
        end
        send_idle_pct = 27;
        take_idle_pct = 27;
    endtask

    // Receiver: stall at random, or hold off for a long stretch on request
    initial
    begin : result_taker
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            out_stall <= ($urandom_range(99) < take_idle_pct);
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin : result_check
        tick_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
                note_failure($sformatf("result %0d with none predicted: event %0d held %0b",
                                       results_seen, event_code, held));
            else
            begin
                want = expected_results.pop_front();
                if (event_code !== want.ev || held !== want.held)
                    note_failure($sformatf(
                        "result %0d: expected event %0d held %0b, got event %0d held %0b",
                        results_seen, want.ev, want.held, event_code, held));
            end
            results_seen++;
        end
    end

    initial
    begin : run_limit
        #16000000;
        $display("button_click_event_detector_tb: errors");
        $finish;
    end

    initial
    begin : run_tests
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        raw_level    = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = bced_pkg::REG_ACTIVE_LEVEL;
        cfg_data     = '0;
        act_level    = 1'b0;
        debounce_len = bced_pkg::DEBOUNCE_RESET;
        long_len     = bced_pkg::LONG_PRESS_RESET;
        window_len   = bced_pkg::CLICK_WINDOW_RESET;
        raw_on       = 1'b0;
        stable_on    = 1'b0;
        raw_age      = '0;
        press_age    = '0;
        release_age  = '0;
        long_done    = 1'b0;
        clicks       = bced_pkg::CLICKS_NONE;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_clicks();
        test_long_press();
        test_zero_settings();
        test_backpressure();
        test_age_limits();
        test_random_phases();

        // Let the pipeline settle, then report
        repeat (4) @(posedge clk);
        if (expected_results.size() != 0)
            note_failure($sformatf("%0d results never arrived", expected_results.size()));
        if (fail_count == 0)
            $display("button_click_event_detector_tb: clean");
        else
            $display("button_click_event_detector_tb: errors");
        $finish;
    end
endmodule

@@ button_click_event_detector.f @@
+incdir+design
design/bced_pkg.sv
design/button_click_event_detector.sv
test/button_click_event_detector_tb.sv
